/* design/hss_pkg.sv */
// ----------------------------------------------------------------------------
// hss_pkg
// Shared types, constants and the coil phase table of the half-step sequencer.
// ----------------------------------------------------------------------------
package hss_pkg;

	localparam int POSITION_BITS = 16;
	localparam int PPQ_BITS      = 12;
	localparam int QUARTER_BITS  = 8;
	localparam int PHASE_BITS    = 3;
	localparam int COIL_BITS     = 4;
	localparam int POS_OUT_BITS  = 16;

	localparam logic [PPQ_BITS-1:0] PPQ_RESET = PPQ_BITS'(139);

	typedef enum logic {
		KIND_COMMAND = 1'b0,
		KIND_TICK    = 1'b1
	} item_kind_t;

	typedef struct packed {
		item_kind_t              kind;
		logic [QUARTER_BITS-1:0] quarter_count;
		logic                    counter_clockwise;
		logic                    edge_hit;
	} in_item_t;

	typedef struct packed {
		logic [COIL_BITS-1:0]           coils;
		logic signed [POS_OUT_BITS-1:0] position;
		logic                           busy_res;
		logic                           move_done;
		logic                           aborted;
	} res_item_t;

	function automatic logic [COIL_BITS-1:0] coil_pattern(input logic [PHASE_BITS-1:0] idx);
		logic [COIL_BITS-1:0] pat;
		unique case (idx)
			3'd0: pat = 4'b0001;
			3'd1: pat = 4'b0011;
			3'd2: pat = 4'b0010;
			3'd3: pat = 4'b0110;
			3'd4: pat = 4'b0100;
			3'd5: pat = 4'b1100;
			3'd6: pat = 4'b1000;
			3'd7: pat = 4'b1001;
			default: pat = '0;
		endcase
		return pat;
	endfunction

	function automatic logic signed [POS_OUT_BITS-1:0] position_field(
		input logic [POSITION_BITS-1:0] pos
	);
		logic signed [31:0] ext;
		ext = 32'(signed'(pos));
		return ext[POS_OUT_BITS-1:0];
	endfunction

endpackage

/* design/hss_in_reg.sv */
// ----------------------------------------------------------------------------
// hss_in_reg
// Input register: captures one item and holds it until the step logic takes it.
// ----------------------------------------------------------------------------
module hss_in_reg
	import hss_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t item_in,
	input  logic     advance,
	output logic     valid_s1,
	output in_item_t item_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_in;
		end
	end

endmodule

/* design/hss_step.sv */
// ----------------------------------------------------------------------------
// hss_step
// Move state and per-item update: phase index, tick and quarter counters,
// position, held coil pattern and abort flag.
// ----------------------------------------------------------------------------
module hss_step
	import hss_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [PPQ_BITS-1:0] cfg_wdata,
	input  logic                advance,
	input  in_item_t            item_s1,
	output res_item_t           result
);

	logic [PPQ_BITS-1:0]      ppq_q;
	logic [PHASE_BITS-1:0]    phase_q, phase_d;
	logic [PPQ_BITS-1:0]      tick_q, tick_d, tick_inc;
	logic [QUARTER_BITS-1:0]  done_q, done_d, done_inc;
	logic [QUARTER_BITS-1:0]  target_q, target_d;
	logic                     dir_q, dir_d;
	logic                     moving_q, moving_d;
	logic [POSITION_BITS-1:0] pos_q, pos_d;
	logic [COIL_BITS-1:0]     coil_q, coil_d;
	logic                     abort_q, abort_d;
	logic                     done_flag;

	always_comb begin
		phase_d   = phase_q;
		tick_d    = tick_q;
		done_d    = done_q;
		target_d  = target_q;
		dir_d     = dir_q;
		moving_d  = moving_q;
		pos_d     = pos_q;
		coil_d    = coil_q;
		abort_d   = abort_q;
		done_flag = 1'b0;
		tick_inc  = tick_q + PPQ_BITS'(1);
		done_inc  = done_q + QUARTER_BITS'(1);
		if (item_s1.kind == KIND_COMMAND) begin
			target_d  = item_s1.quarter_count;
			dir_d     = item_s1.counter_clockwise;
			done_d    = '0;
			tick_d    = '0;
			phase_d   = '0;
			abort_d   = 1'b0;
			moving_d  = item_s1.quarter_count != '0;
			done_flag = item_s1.quarter_count == '0;
		end else if (moving_q) begin
			if (tick_q == '0 && item_s1.edge_hit) begin
				moving_d  = 1'b0;
				abort_d   = 1'b1;
				done_flag = 1'b1;
			end else begin
				coil_d  = coil_pattern(phase_q);
				phase_d = dir_q ? phase_q + PHASE_BITS'(1) : phase_q - PHASE_BITS'(1);
				tick_d  = tick_inc;
				if (tick_inc == '0 || tick_inc >= ppq_q) begin
					tick_d = '0;
					pos_d  = dir_q ? pos_q - POSITION_BITS'(1) : pos_q + POSITION_BITS'(1);
					done_d = done_inc;
					if (done_inc == target_q) begin
						moving_d  = 1'b0;
						done_flag = 1'b1;
					end
				end
			end
		end
		result.coils     = coil_d;
		result.position  = position_field(pos_d);
		result.busy_res  = moving_d;
		result.move_done = done_flag;
		result.aborted   = abort_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppq_q    <= PPQ_RESET;
			phase_q  <= '0;
			tick_q   <= '0;
			done_q   <= '0;
			target_q <= '0;
			dir_q    <= 1'b0;
			moving_q <= 1'b0;
			pos_q    <= '0;
			coil_q   <= '0;
			abort_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				ppq_q <= cfg_wdata;
			end
			if (advance) begin
				phase_q  <= phase_d;
				tick_q   <= tick_d;
				done_q   <= done_d;
				target_q <= target_d;
				dir_q    <= dir_d;
				moving_q <= moving_d;
				pos_q    <= pos_d;
				coil_q   <= coil_d;
				abort_q  <= abort_d;
			end
		end
	end

endmodule

/* design/hss_out_reg.sv */
// ----------------------------------------------------------------------------
// hss_out_reg
// Result register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module hss_out_reg
	import hss_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      valid_s1,
	input  res_item_t result,
	input  logic      out_ready,
	output logic      advance,
	output logic      valid_s2,
	output res_item_t result_s2
);

	assign advance = valid_s1 && (!valid_s2 || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

endmodule

/* design/half_step_stepper_mover.sv */
// ----------------------------------------------------------------------------
// half_step_stepper_mover
// Half-step sequencer for one axis of a four-coil unipolar stepper.
//
// Input channel (in_valid/in_ready) takes command items (kind 0: quarter
// count and direction) and tick items (kind 1: one step period, with the
// limit sensor). Every item gives exactly one result item on the output
// channel (out_valid/out_ready): coil drive, position, busy, done, aborted.
// cfg_we/cfg_wdata write phases_per_quarter. The user must write it only
// while the block is idle; the block itself does not enforce this.
//
// An accepted item waits in the input register until the state update
// between the input and result registers steps it into the result register.
// Throughput: one item per cycle while the receiver does not stall.
// A stalled receiver holds the result register; the input register still
// takes one more item, after which in_ready drops until out_ready returns.
// Reset clears all move state, position and coils to zero, sets
// phases_per_quarter to 139 and empties both registers.
// ----------------------------------------------------------------------------
module half_step_stepper_mover
	import hss_pkg::*;
(
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [PPQ_BITS-1:0]            cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           kind,
	input  logic [QUARTER_BITS-1:0]        quarter_count,
	input  logic                           counter_clockwise,
	input  logic                           edge_hit,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [COIL_BITS-1:0]           coils,
	output logic signed [POS_OUT_BITS-1:0] position,
	output logic                           busy_res,
	output logic                           move_done,
	output logic                           aborted
);

	in_item_t  item_in, item_s1;
	res_item_t result, result_s2;
	logic      valid_s1, advance;

	assign item_in.kind              = item_kind_t'(kind);
	assign item_in.quarter_count     = quarter_count;
	assign item_in.counter_clockwise = counter_clockwise;
	assign item_in.edge_hit          = edge_hit;

	hss_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.item_in  (item_in),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	hss_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.advance   (advance),
		.item_s1   (item_s1),
		.result    (result)
	);

	hss_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.result    (result),
		.out_ready (out_ready),
		.advance   (advance),
		.valid_s2  (out_valid),
		.result_s2 (result_s2)
	);

	assign coils     = result_s2.coils;
	assign position  = result_s2.position;
	assign busy_res  = result_s2.busy_res;
	assign move_done = result_s2.move_done;
	assign aborted   = result_s2.aborted;

endmodule

/* design/hss_checker.sv */
// ----------------------------------------------------------------------------
// hss_checker
// Port-level checks of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module hss_checker
	import hss_pkg::*;
(
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [COIL_BITS-1:0]           coils,
	input logic signed [POS_OUT_BITS-1:0] position,
	input logic                           busy_res,
	input logic                           move_done,
	input logic                           aborted
);

	// a held result keeps its value
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(coils) && $stable(position)
			&& $stable(move_done))
		else $error("stalled result item changed");

	// a finished move is never still busy
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && move_done |-> !busy_res)
		else $error("move_done with busy_res");

	// half-step patterns energise at most two adjacent coils
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $countones(coils) <= 2 && coils != 4'b0101 && coils != 4'b1010)
		else $error("illegal coil pattern");

	// an abort flag on a busy result cannot appear
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && aborted |-> !busy_res)
		else $error("aborted while busy");

endmodule

bind half_step_stepper_mover hss_checker u_hss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.coils     (coils),
	.position  (position),
	.busy_res  (busy_res),
	.move_done (move_done),
	.aborted   (aborted)
);

/* sim/half_step_stepper_mover_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// half_step_stepper_mover_tb
// Self-checking bench for the half-step stepper sequencer.
//
// A short table of directed items (reset state, empty moves, limit aborts,
// register extremes, a shortened quarter, a command cutting into a move) is
// followed by random move sequences under four handshake regimes. Every
// accepted item is run through a behavioural copy of the sequencer, and each
// result item is checked, in order and by field, against it or a table row.
// ----------------------------------------------------------------------------
module half_step_stepper_mover_tb;
	import hss_pkg::*;

	localparam int WATCHDOG_CYCLES = 5000;
	localparam int SETTLE_CYCLES   = 3;
	localparam int LIVE_PER_PHASE  = 100;

	localparam logic [COIL_BITS-1:0] HALF_STEP_COILS [8] = '{
		4'b0001, 4'b0011, 4'b0010, 4'b0110, 4'b0100, 4'b1100, 4'b1000, 4'b1001
	};

	typedef struct packed {
		logic                cfg;
		logic [PPQ_BITS-1:0] ppq;
		in_item_t            item;
		logic                typed;
		res_item_t           want;
	} drill_row_t;

	localparam drill_row_t DRILL [23] = '{
		'{1'b0, 12'd0,    '{KIND_TICK,    8'd0,   1'b0, 1'b1}, 1'b1, '{4'd0, 16'sd0, 1'b0, 1'b0, 1'b0}},
		'{1'b0, 12'd0,    '{KIND_COMMAND, 8'd0,   1'b1, 1'b0}, 1'b1, '{4'd0, 16'sd0, 1'b0, 1'b1, 1'b0}},
		'{1'b1, 12'd1,    '0,                                   1'b0, '0},
		'{1'b0, 12'd0,    '{KIND_COMMAND, 8'd2,   1'b0, 1'b1}, 1'b1, '{4'd0, 16'sd0, 1'b1, 1'b0, 1'b0}},
		'{1'b0, 12'd0,    '{KIND_TICK,    8'd0,   1'b0, 1'b0}, 1'b0, '0},
		'{1'b0, 12'd0,    '{KIND_TICK,    8'd0,   1'b0, 1'b0}, 1'b0, '0},
		'{1'b0, 12'd0,    '{KIND_TICK,    8'd255, 1'b1, 1'b1}, 1'b0, '0},
		'{1'b0, 12'd0,    '{KIND_COMMAND, 8'd255, 1'b1, 1'b0}, 1'b0, '0},
		'{1'b0, 12'd0,    '{KIND_TICK,    8'd0,   1'b0, 1'b1}, 1'b0, '0},
		'{1'b0, 12'd0,    '{KIND_TICK,    8'd0,   1'b0, 1'b0}, 1'b0, '0},
		'{1'b1, 12'd4095, '0,                                   1'b0, '0},
		'{1'b0, 12'd0,    '{KIND_COMMAND, 8'd1,   1'b1, 1'b0}, 1'b0, '0},
		'{1'b0, 12'd0,    '{KIND_TICK,    8'd0,   1'b0, 1'b0}, 1'b0, '0},
		'{1'b0, 12'd0,    '{KIND_TICK,    8'd0,   1'b0, 1'b1}, 1'b0, '0},
		'{1'b0, 12'd0,    '{KIND_TICK,    8'd0,   1'b0, 1'b1}, 1'b0, '0},
		'{1'b1, 12'd2,    '0,                                   1'b0, '0},
		'{1'b0, 12'd0,    '{KIND_TICK,    8'd0,   1'b0, 1'b1}, 1'b0, '0},
		'{1'b1, 12'd0,    '0,                                   1'b0, '0},
		'{1'b0, 12'd0,    '{KIND_COMMAND, 8'd3,   1'b0, 1'b0}, 1'b0, '0},
		'{1'b0, 12'd0,    '{KIND_TICK,    8'd0,   1'b0, 1'b0}, 1'b0, '0},
		'{1'b0, 12'd0,    '{KIND_COMMAND, 8'd1,   1'b1, 1'b0}, 1'b0, '0},
		'{1'b0, 12'd0,    '{KIND_TICK,    8'd0,   1'b0, 1'b0}, 1'b0, '0},
		'{1'b0, 12'd0,    '{KIND_TICK,    8'd0,   1'b0, 1'b0}, 1'b0, '0}
	};

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [PPQ_BITS-1:0]            cfg_wdata = '0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic                           kind = 1'b0;
	logic [QUARTER_BITS-1:0]        quarter_count = '0;
	logic                           counter_clockwise = 1'b0;
	logic                           edge_hit = 1'b0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [COIL_BITS-1:0]           coils;
	logic signed [POS_OUT_BITS-1:0] position;
	logic                           busy_res;
	logic                           move_done;
	logic                           aborted;

	// sequencer state as the bench sees it
	logic [PPQ_BITS-1:0]      quarter_len = PPQ_RESET;
	logic [PHASE_BITS-1:0]    phase_idx = '0;
	logic [PPQ_BITS-1:0]      tick_in_quarter = '0;
	logic [QUARTER_BITS-1:0]  quarters_moved = '0;
	logic [QUARTER_BITS-1:0]  quarters_wanted = '0;
	logic                     dir_ccw = 1'b0;
	logic                     running = 1'b0;
	logic                     hit_limit = 1'b0;
	logic [POSITION_BITS-1:0] axis_pos = '0;
	logic [COIL_BITS-1:0]     held_coils = '0;

	res_item_t axis_results_q [$];
	int        mismatches = 0;
	int        gap_pct = 0;
	int        stall_pct = 0;
	int        hold_req = 0;
	int        hold_left = 0;
	int        quiet_cycles = 0;

	half_step_stepper_mover uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.kind              (kind),
		.quarter_count     (quarter_count),
		.counter_clockwise (counter_clockwise),
		.edge_hit          (edge_hit),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.coils             (coils),
		.position          (position),
		.busy_res          (busy_res),
		.move_done         (move_done),
		.aborted           (aborted)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic res_item_t step_axis(input in_item_t it);
		res_item_t res;
		logic      done;
		done = 1'b0;
		if (it.kind == KIND_COMMAND) begin
			quarters_wanted = it.quarter_count;
			dir_ccw = it.counter_clockwise;
			quarters_moved = '0;
			tick_in_quarter = '0;
			phase_idx = '0;
			hit_limit = 1'b0;
			running = (it.quarter_count != '0);
			done = !running;
		end else if (running) begin
			if (tick_in_quarter == '0 && it.edge_hit) begin
				running = 1'b0;
				hit_limit = 1'b1;
				done = 1'b1;
			end else begin
				held_coils = HALF_STEP_COILS[phase_idx];
				phase_idx = dir_ccw ? phase_idx + 3'd1 : phase_idx - 3'd1;
				tick_in_quarter = tick_in_quarter + 12'd1;
				if (tick_in_quarter == '0 || tick_in_quarter >= quarter_len) begin
					tick_in_quarter = '0;
					axis_pos = dir_ccw ? axis_pos - POSITION_BITS'(1)
						: axis_pos + POSITION_BITS'(1);
					quarters_moved = quarters_moved + 8'd1;
					if (quarters_moved == quarters_wanted) begin
						running = 1'b0;
						done = 1'b1;
					end
				end
			end
		end
		res.coils = held_coils;
		res.position = POS_OUT_BITS'(signed'(axis_pos));
		res.busy_res = running;
		res.move_done = done;
		res.aborted = hit_limit;
		return res;
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		it.kind = ($urandom_range(99) < 12) ? KIND_COMMAND : KIND_TICK;
		it.counter_clockwise = 1'($urandom_range(1));
		if (it.kind == KIND_COMMAND) begin
			it.quarter_count = ($urandom_range(7) == 0) ? 8'($urandom_range(255))
				: 8'($urandom_range(4));
			it.edge_hit = 1'($urandom_range(1));
		end else begin
			it.quarter_count = 8'($urandom);
			it.edge_hit = ($urandom_range(11) == 0);
		end
		return it;
	endfunction

	task automatic send_item(input in_item_t it, input logic typed, input res_item_t want,
			output logic live);
		res_item_t predicted;
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		kind <= it.kind;
		quarter_count <= it.quarter_count;
		counter_clockwise <= it.counter_clockwise;
		edge_hit <= it.edge_hit;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		live = !(it.kind == KIND_TICK && !running);
		predicted = step_axis(it);
		axis_results_q.push_back(typed ? want : predicted);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (axis_results_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_quarter_len(input logic [PPQ_BITS-1:0] value);
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		quarter_len = value;
	endtask

	// receiver side: random stalls plus one long hold
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req != 0) begin
				out_ready <= 1'b0;
				hold_left = hold_req;
				hold_req = 0;
			end else if (hold_left != 0) begin
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin : result_check
		res_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (axis_results_q.size() == 0) begin
				$error("result item with nothing expected");
				mismatches++;
			end else begin
				want = axis_results_q.pop_front();
				if (coils !== want.coils) begin
					$error("coils: expected %0h, got %0h", want.coils, coils);
					mismatches++;
				end
				if (position !== want.position) begin
					$error("position: expected %0d, got %0d", want.position, position);
					mismatches++;
				end
				if (busy_res !== want.busy_res) begin
					$error("busy_res: expected %0b, got %0b", want.busy_res, busy_res);
					mismatches++;
				end
				if (move_done !== want.move_done) begin
					$error("move_done: expected %0b, got %0b", want.move_done, move_done);
					mismatches++;
				end
				if (aborted !== want.aborted) begin
					$error("aborted: expected %0b, got %0b", want.aborted, aborted);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_CYCLES) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		logic [PPQ_BITS-1:0] phase_len [4];
		int                  phase_gap [4];
		int                  phase_stall [4];
		int                  live_seen;
		int                  sent;
		logic                live;
		phase_len = '{12'd2, 12'd1, 12'd0, 12'd5};
		phase_len[2] = PPQ_BITS'($urandom_range(3, 6));
		phase_gap = '{0, 49, 0, 28};
		phase_stall = '{0, 0, 49, 28};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (DRILL[i]) begin
			if (DRILL[i].cfg) begin
				drain_results();
				write_quarter_len(DRILL[i].ppq);
			end else begin
				send_item(DRILL[i].item, DRILL[i].typed, DRILL[i].want, live);
			end
		end

		// random move sequences
		for (int p = 0; p < 4; p++) begin
			drain_results();
			write_quarter_len(phase_len[p]);
			gap_pct = phase_gap[p];
			stall_pct = phase_stall[p];
			live_seen = 0;
			sent = 0;
			while (live_seen < LIVE_PER_PHASE) begin
				send_item(random_item(), 1'b0, '0, live);
				if (live)
					live_seen++;
				sent++;
				if (p == 0 && sent == 30)
					hold_req = 150;
				if (p == 0 && sent == 60)
					drain_results();
			end
		end

		drain_results();
		if (mismatches == 0 && axis_results_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
